// ----- src/vtfp_pkg.sv -----
// ----------------------------------------------------------------------------
// vtfp_pkg
// types and constants shared by the transaction field parser
// ----------------------------------------------------------------------------
`default_nettype none

package vtfp_pkg;

	localparam logic [3:0] PH_VER    = 4'd0;
	localparam logic [3:0] PH_INCNT  = 4'd1;
	localparam logic [3:0] PH_PHASH  = 4'd2;
	localparam logic [3:0] PH_PIDX   = 4'd3;
	localparam logic [3:0] PH_SIGLEN = 4'd4;
	localparam logic [3:0] PH_SIG    = 4'd5;
	localparam logic [3:0] PH_SEQ    = 4'd6;
	localparam logic [3:0] PH_OUTCNT = 4'd7;
	localparam logic [3:0] PH_VALUE  = 4'd8;
	localparam logic [3:0] PH_PKLEN  = 4'd9;
	localparam logic [3:0] PH_PKS    = 4'd10;
	localparam logic [3:0] PH_LOCK   = 4'd11;

	localparam logic [7:0] VARINT_P16 = 8'hfd;
	localparam logic [7:0] VARINT_P32 = 8'hfe;

	localparam logic [3:0] VARINT_LEN16 = 4'd2;
	localparam logic [3:0] VARINT_LEN32 = 4'd4;
	localparam logic [3:0] VARINT_LEN64 = 4'd8;

	localparam logic [3:0] FIXED_LEN4 = 4'd4;
	localparam logic [3:0] FIXED_LEN8 = 4'd8;

	localparam logic [63:0] PHASH_LEN = 64'd32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [3:0]  field_class;
		logic        field_done;
		logic [63:0] field_value;
		logic [31:0] element_index;
		logic        tx_done;
		logic [23:0] tx_length;
		logic        truncated;
	} out_t;

endpackage

`default_nettype wire

// ----- src/vtfp_core.sv -----
// ----------------------------------------------------------------------------
// vtfp_core
// parser state and the single-pass field decode for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module vtfp_core #(
	parameter int INDEX_WIDTH  = 32,
	parameter int LENGTH_WIDTH = 24
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  fire,
	input  wire vtfp_pkg::in_t   item,
	output vtfp_pkg::out_t       res
);

	logic [3:0]              phase_q, phase_d;
	logic [3:0]              fbc_q, fbc_d;
	logic [3:0]              vleft_q, vleft_d;
	logic [63:0]             acc_q, acc_d;
	logic [63:0]             eleft_q, eleft_d;
	logic [63:0]             sleft_q, sleft_d;
	logic [INDEX_WIDTH-1:0]  ecnt_q, ecnt_d;
	logic [LENGTH_WIDTH-1:0] txcnt_q, txcnt_d;

	always_comb begin
		logic                    bad;
		logic [3:0]              ph;
		logic [3:0]              fbc;
		logic [3:0]              vleft;
		logic [63:0]             acc;
		logic [7:0]              b;
		logic [63:0]             b64;
		logic [3:0]              fbc_inc;
		logic [63:0]             acc_f;
		logic [63:0]             acc_v;
		logic [3:0]              vleft_dec;
		logic                    var_done;
		logic [63:0]             var_val;
		logic [63:0]             sl_dec;
		logic [63:0]             el_dec;
		logic [INDEX_WIDTH-1:0]  ecnt_inc;
		logic [LENGTH_WIDTH-1:0] txc_inc;
		logic                    done;
		logic                    txd;
		logic [63:0]             val;
		logic [63:0]             len_ext;
		logic [63:0]             idx_ext;
		logic                    do_next;
		logic [3:0]              again;
		logic [3:0]              after;

		bad   = phase_q > vtfp_pkg::PH_LOCK;
		ph    = bad ? vtfp_pkg::PH_VER : phase_q;
		fbc   = bad ? 4'd0 : fbc_q;
		vleft = bad ? 4'd0 : vleft_q;
		acc   = bad ? 64'd0 : acc_q;
		b     = item.data_byte;

		fbc_inc = 4'(fbc + 4'd1);
		b64     = 64'(b);
		acc_f   = acc | (b64 << {fbc[2:0], 3'b000});
		acc_v   = acc | (b64 << {3'(fbc[2:0] - 3'd1), 3'b000});

		vleft_dec = (vleft != 4'd0) ? 4'(vleft - 4'd1) : vleft;
		sl_dec    = (sleft_q != 64'd0) ? 64'(sleft_q - 64'd1) : sleft_q;
		el_dec    = (eleft_q != 64'd0) ? 64'(eleft_q - 64'd1) : eleft_q;
		ecnt_inc  = (&ecnt_q) ? ecnt_q : INDEX_WIDTH'(ecnt_q + 1'b1);
		txc_inc   = (&txcnt_q) ? txcnt_q : LENGTH_WIDTH'(txcnt_q + 1'b1);

		phase_d = ph;
		fbc_d   = fbc;
		vleft_d = vleft;
		acc_d   = acc;
		eleft_d = eleft_q;
		sleft_d = sleft_q;
		ecnt_d  = ecnt_q;
		txcnt_d = txc_inc;

		// varint step
		var_done = 1'b0;
		var_val  = 64'd0;
		if (fbc == 4'd0) begin
			if (b < vtfp_pkg::VARINT_P16) begin
				var_done = 1'b1;
				var_val  = b64;
			end
		end else if (vleft_dec == 4'd0) begin
			var_done = 1'b1;
			var_val  = acc_v;
		end

		done    = 1'b0;
		txd     = 1'b0;
		val     = 64'd0;
		do_next = 1'b0;
		again   = vtfp_pkg::PH_VALUE;
		after   = vtfp_pkg::PH_LOCK;

		unique case (ph)
			vtfp_pkg::PH_VER, vtfp_pkg::PH_PIDX, vtfp_pkg::PH_SEQ,
			vtfp_pkg::PH_VALUE, vtfp_pkg::PH_LOCK: begin
				fbc_d = fbc_inc;
				acc_d = acc_f;
				if (fbc_inc >= ((ph == vtfp_pkg::PH_VALUE) ? vtfp_pkg::FIXED_LEN8
						: vtfp_pkg::FIXED_LEN4)) begin
					done    = 1'b1;
					val     = acc_f;
					fbc_d   = 4'd0;
					vleft_d = 4'd0;
					acc_d   = 64'd0;
					unique case (ph)
						vtfp_pkg::PH_VER:   phase_d = vtfp_pkg::PH_INCNT;
						vtfp_pkg::PH_PIDX:  phase_d = vtfp_pkg::PH_SIGLEN;
						vtfp_pkg::PH_VALUE: phase_d = vtfp_pkg::PH_PKLEN;
						vtfp_pkg::PH_SEQ: begin
							do_next = 1'b1;
							again   = vtfp_pkg::PH_PHASH;
							after   = vtfp_pkg::PH_OUTCNT;
						end
						default: txd = 1'b1;
					endcase
				end
			end
			vtfp_pkg::PH_INCNT, vtfp_pkg::PH_SIGLEN,
			vtfp_pkg::PH_OUTCNT, vtfp_pkg::PH_PKLEN: begin
				if (var_done) begin
					done    = 1'b1;
					val     = var_val;
					fbc_d   = 4'd0;
					vleft_d = 4'd0;
					acc_d   = 64'd0;
					unique case (ph)
						vtfp_pkg::PH_INCNT: begin
							eleft_d = var_val;
							ecnt_d  = '0;
							if (var_val != 64'd0) begin
								sleft_d = vtfp_pkg::PHASH_LEN;
								phase_d = vtfp_pkg::PH_PHASH;
							end else begin
								phase_d = vtfp_pkg::PH_OUTCNT;
							end
						end
						vtfp_pkg::PH_OUTCNT: begin
							eleft_d = var_val;
							ecnt_d  = '0;
							phase_d = (var_val != 64'd0) ? vtfp_pkg::PH_VALUE
								: vtfp_pkg::PH_LOCK;
						end
						vtfp_pkg::PH_SIGLEN: begin
							if (var_val != 64'd0) begin
								sleft_d = var_val;
								phase_d = vtfp_pkg::PH_SIG;
							end else begin
								phase_d = vtfp_pkg::PH_SEQ;
							end
						end
						default: begin
							if (var_val != 64'd0) begin
								sleft_d = var_val;
								phase_d = vtfp_pkg::PH_PKS;
							end else begin
								do_next = 1'b1;
							end
						end
					endcase
				end else if (fbc == 4'd0) begin
					fbc_d   = 4'd1;
					acc_d   = 64'd0;
					vleft_d = (b == vtfp_pkg::VARINT_P16) ? vtfp_pkg::VARINT_LEN16
						: (b == vtfp_pkg::VARINT_P32) ? vtfp_pkg::VARINT_LEN32
						: vtfp_pkg::VARINT_LEN64;
				end else begin
					fbc_d   = fbc_inc;
					acc_d   = acc_v;
					vleft_d = vleft_dec;
				end
			end
			default: begin
				// prevhash, sig and pkscript bytes
				sleft_d = sl_dec;
				if (sl_dec == 64'd0) begin
					done = 1'b1;
					unique case (ph)
						vtfp_pkg::PH_PHASH: phase_d = vtfp_pkg::PH_PIDX;
						vtfp_pkg::PH_SIG:   phase_d = vtfp_pkg::PH_SEQ;
						default:            do_next = 1'b1;
					endcase
				end
			end
		endcase

		if (do_next) begin
			eleft_d = el_dec;
			if (el_dec == 64'd0) begin
				ecnt_d  = '0;
				phase_d = after;
			end else begin
				ecnt_d  = ecnt_inc;
				phase_d = again;
				if (again == vtfp_pkg::PH_PHASH) begin
					sleft_d = vtfp_pkg::PHASH_LEN;
				end
			end
		end

		if (txd || item.last_byte) begin
			phase_d = vtfp_pkg::PH_VER;
			fbc_d   = 4'd0;
			vleft_d = 4'd0;
			acc_d   = 64'd0;
			eleft_d = 64'd0;
			sleft_d = 64'd0;
			ecnt_d  = '0;
			txcnt_d = '0;
		end

		len_ext = 64'(txc_inc);
		idx_ext = 64'(ecnt_q);

		res.byte_value    = b;
		res.field_class   = ph;
		res.field_done    = done;
		res.field_value   = val;
		res.element_index = (idx_ext > 64'hffff_ffff) ? 32'hffff_ffff : idx_ext[31:0];
		res.tx_done       = txd;
		res.tx_length     = !txd ? 24'd0
			: (len_ext > 64'hff_ffff) ? 24'hff_ffff : len_ext[23:0];
		res.truncated     = item.last_byte && !txd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vtfp_pkg::PH_VER;
			fbc_q   <= 4'd0;
			vleft_q <= 4'd0;
			acc_q   <= 64'd0;
			eleft_q <= 64'd0;
			sleft_q <= 64'd0;
			ecnt_q  <= '0;
			txcnt_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			fbc_q   <= fbc_d;
			vleft_q <= vleft_d;
			acc_q   <= acc_d;
			eleft_q <= eleft_d;
			sleft_q <= sleft_d;
			ecnt_q  <= ecnt_d;
			txcnt_q <= txcnt_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/varint_transaction_field_parser_top.sv -----
// ----------------------------------------------------------------------------
// varint_transaction_field_parser_top
// byte-serial parser for legacy serialized transactions
// ----------------------------------------------------------------------------
// One byte is taken per clock and one tagged result leaves per clock while
// result_stall is low: the byte sits in the input register, the field decode
// against the parser state runs in one pass, and the result register holds
// the tagged byte. The sustained rate of one byte a clock is set by that
// one-pass decode and state update. No clearing pass follows reset.
`default_nettype none

module varint_transaction_field_parser_top #(
	parameter int INDEX_WIDTH  = 32,
	parameter int LENGTH_WIDTH = 24
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  wire vtfp_pkg::in_t   item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output vtfp_pkg::out_t       result
);

	logic           valid_s1;
	vtfp_pkg::in_t  item_s1;
	logic           valid_s2;
	vtfp_pkg::out_t result_s2;
	vtfp_pkg::out_t res_c;
	logic           load_s2;
	logic           fire;

	assign load_s2    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && load_s2;
	assign item_stall = valid_s1 && !load_s2;

	vtfp_core #(
		.INDEX_WIDTH (INDEX_WIDTH),
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.res   (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (load_s2) begin
				valid_s2 <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_s2 <= res_c;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

`default_nettype wire

// ----- src/vtfp_checker.sv -----
// ----------------------------------------------------------------------------
// vtfp_checker
// port-level checks on the transaction field parser
// ----------------------------------------------------------------------------
`default_nettype none

module vtfp_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  item_valid,
	input wire                  item_stall,
	input wire vtfp_pkg::in_t   item,
	input wire                  result_valid,
	input wire                  result_stall,
	input wire vtfp_pkg::out_t  result
);

	// a stalled result request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_txd_lock: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.tx_done |->
			result.field_done && result.field_class == vtfp_pkg::PH_LOCK)
		else $error("tx_done outside closing lock time byte");

	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.truncated |-> !result.tx_done)
		else $error("truncated with tx_done");

	a_val_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.field_done |->
			result.field_value == 64'd0 && result.tx_length == 24'd0)
		else $error("value reported on open field");

	// after a completed or truncated transaction the next result starts a version field
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && (result.tx_done || result.truncated) ##1
			result_valid |-> result.field_class == vtfp_pkg::PH_VER)
		else $error("no restart after transaction end");

endmodule

bind varint_transaction_field_parser_top vtfp_checker u_vtfp_checker (.*);

`default_nettype wire
